FILE: design/dwc3_pkg.sv
// Shared types and constants for the depthwise 3x3 int8 convolution block.
// No dependencies; imported by the requantizer and the top level.
`timescale 1ns / 1ps

package dwc3_pkg;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_CHANNELS = 32;

    localparam int ACC_W  = 19;
    localparam int MULT_W = 32;
    localparam int COEF_W = 48;
    localparam int PROD_W = ACC_W + MULT_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHIFT_MAX = 47;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_MULT   = 2'd2;
    localparam logic [1:0] KIND_BIAS   = 2'd3;

    localparam logic [2:0] REG_HEIGHT = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_CHANS  = 3'd2;
    localparam logic [2:0] REG_STRIDE = 3'd3;
    localparam logic [2:0] REG_PAD    = 3'd4;
    localparam logic [2:0] REG_RELU   = 3'd5;
    localparam logic [2:0] REG_SHIFT  = 3'd6;

    typedef struct packed {
        logic       start;
        logic       relu;
        logic [5:0] shift;
    } rq_ctrl_t;

endpackage

FILE: design/dwc3_requant.sv
// Three-stage requantizer: multiply, add bias with optional relu, round and clamp.
// Depends on dwc3_pkg.
`timescale 1ns / 1ps

module dwc3_requant (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dwc3_pkg::rq_ctrl_t                      ctrl,
    input  logic signed [dwc3_pkg::ACC_W-1:0]       acc,
    input  logic        [dwc3_pkg::MULT_W-1:0]      mult,
    input  logic signed [dwc3_pkg::COEF_W-1:0]      bias,
    output logic                                    done,
    output logic signed [7:0]                       value
);
    import dwc3_pkg::*;

    logic                     v1_reg, v2_reg, done_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  q;
    logic        [SUM_W-1:0]  rem, half, mask;
    logic signed [SUM_W-1:0]  qr;
    logic                     up;
    logic signed [7:0]        value_reg, value_next;

    always_comb
    begin
        sum_next = SUM_W'(prod_reg) + SUM_W'(bias);
        if (ctrl.relu && sum_next < 0)
        begin
            sum_next = '0;
        end
    end

    // Floor shift, then round half to even on the discarded bits.
    always_comb
    begin
        q    = sum_reg >>> ctrl.shift;
        mask = (SUM_W'(1) << ctrl.shift) - SUM_W'(1);
        rem  = sum_reg & mask;
        half = (ctrl.shift == 6'd0) ? '0 : (SUM_W'(1) << (ctrl.shift - 6'd1));
        up   = (ctrl.shift != 6'd0) && ((rem > half) || ((rem == half) && q[0]));
        qr   = q + SUM_W'(up);
        if (qr > 127)
        begin
            value_next = 8'sd127;
        end
        else if (qr < -128)
        begin
            value_next = -8'sd128;
        end
        else
        begin
            value_next = qr[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.start;
            v2_reg <= v1_reg;
            if (ctrl.start)
            begin
                done_reg <= 1'b0;
            end
            else if (v2_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            prod_reg <= acc * $signed({1'b0, mult});
        end
        if (v1_reg)
        begin
            sum_reg <= sum_next;
        end
        if (v2_reg)
        begin
            value_reg <= value_next;
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

FILE: design/depthwise_conv3x3_int8_requant_unit.sv
// Depthwise 3x3 int8 convolution with fixed-point requantization, top level.
// Sequence: a load is taken in the idle state; a pixel goes through the plan and find
// states, then each output (0 to 4) through taps, drain, start and emit, with emit
// waiting while a finished result is held back by out_stall. Throughput: one request at
// a time; the nine-tap loop runs through one 8x8 multiplier and the line store read port.
// Reset: counters clear, registers take their defaults, biases read as zero.
// Depends on dwc3_pkg and dwc3_requant.
`timescale 1ns / 1ps

module depthwise_conv3x3_int8_requant_unit #(
    parameter int MAX_WIDTH    = dwc3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = dwc3_pkg::DEF_MAX_CHANNELS,
    parameter int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic signed [7:0]   sample_value,
    input  logic [4:0]          chan_index,
    input  logic [3:0]          tap_index,
    input  logic signed [47:0]  coefficient,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [7:0]   out_value,
    output logic [11:0]         out_row,
    output logic [COL_W-1:0]    out_col,
    output logic [CH_W-1:0]     out_chan,
    output logic                last_of_run
);
    import dwc3_pkg::*;

    localparam int STORE_ROW = MAX_WIDTH * MAX_CHANNELS;
    localparam int LS_DEPTH  = 3 * STORE_ROW;
    localparam int LS_AW     = $clog2(LS_DEPTH);
    localparam int WT_DEPTH  = 9 * MAX_CHANNELS;
    localparam int WT_AW     = $clog2(WT_DEPTH);
    localparam int GW        = 15;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PLAN, ST_FIND, ST_TAP, ST_DRAIN, ST_START, ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [12:0] height_reg;
    logic [8:0]  width_reg;
    logic [5:0]  chans_reg;
    logic [1:0]  stride_reg;
    logic        pad_reg, relu_reg;
    logic [5:0]  shift_reg;

    logic [11:0]      row_reg;
    logic [COL_W-1:0] col_reg;
    logic [CH_W-1:0]  chan_reg;
    logic [1:0]       slot_reg;

    logic [11:0]      cur_r_reg;
    logic [COL_W-1:0] cur_c_reg;
    logic [CH_W-1:0]  cur_ch_reg;
    logic [1:0]       cur_slot_reg;

    logic signed [GW-1:0] oy0_reg, ox0_reg;
    logic [3:0]           cand_mask_reg;
    logic [1:0]           cand_reg;
    logic                 last_reg;

    logic [3:0]           tap_reg;
    logic [1:0]           ky_reg, kx_reg;
    logic                 tap_v_reg, tap_ok_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [7:0] line_store [LS_DEPTH];
    logic signed [7:0] weight_mem [WT_DEPTH];
    logic [MULT_W-1:0] mult_mem   [MAX_CHANNELS];
    logic signed [COEF_W-1:0] bias_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]  bias_ok_reg;

    logic signed [7:0]        ls_rd_reg, wt_rd_reg;
    logic [MULT_W-1:0]        mult_rd_reg;
    logic signed [COEF_W-1:0] bias_rd_reg;

    logic                out_valid_reg, last_of_run_reg;
    logic signed [7:0]   out_value_reg;
    logic [11:0]         out_row_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [CH_W-1:0]     out_chan_reg;

    // Clamped geometry.
    logic signed [GW-1:0] h_s, w_s, c_s, p_s;
    logic                 s2;
    logic [5:0]           k_eff;

    always_comb
    begin
        h_s = (height_reg == 13'd0) ? GW'(1) :
              (height_reg > 13'd4096) ? GW'(4096) : GW'(height_reg);
        w_s = (width_reg == 9'd0) ? GW'(1) :
              (GW'(width_reg) > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : GW'(width_reg);
        c_s = (chans_reg == 6'd0) ? GW'(1) :
              (GW'(chans_reg) > GW'(MAX_CHANNELS)) ? GW'(MAX_CHANNELS) : GW'(chans_reg);
        p_s = GW'(pad_reg);
        s2  = stride_reg[1];
        k_eff = (shift_reg > 6'(SHIFT_MAX)) ? 6'(SHIFT_MAX) : shift_reg;
    end

    // APB port.
    logic       cfg_wr;
    logic [2:0] cfg_idx;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_CHANS:  prdata = 32'(chans_reg);
            REG_STRIDE: prdata = 32'(stride_reg);
            REG_PAD:    prdata = 32'(pad_reg);
            REG_RELU:   prdata = 32'(relu_reg);
            REG_SHIFT:  prdata = 32'(shift_reg);
            default:    prdata = '0;
        endcase
    end

    logic accept, is_pixel, load_ok;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign is_pixel = (kind == KIND_PIXEL);
    assign load_ok  = (32'(chan_index) < 32'(MAX_CHANNELS));

    // Output candidates of the current pixel, worked out in the plan state.
    logic signed [GW-1:0] by, bx, oy0, ox0, oh, ow, ry, cx;
    logic [1:0]           vy, vx;
    logic                 size_ok;

    function automatic logic completes(input logic signed [GW-1:0] o,
                                       input logic sel2,
                                       input logic signed [GW-1:0] p,
                                       input logic signed [GW-1:0] n,
                                       input logic signed [GW-1:0] on,
                                       input logic signed [GW-1:0] x);
        logic signed [GW-1:0] last;
        begin
            last = (sel2 ? (o <<< 1) : o) - p + GW'(2);
            if (last > n - GW'(1))
            begin
                last = n - GW'(1);
            end
            completes = (o < on) && (last == x);
        end
    endfunction

    always_comb
    begin
        ry  = GW'(cur_r_reg);
        cx  = GW'(cur_c_reg);
        by  = ry + p_s - GW'(2);
        bx  = cx + p_s - GW'(2);
        oy0 = (by <= 0) ? '0 : (s2 ? ((by + GW'(1)) >>> 1) : by);
        ox0 = (bx <= 0) ? '0 : (s2 ? ((bx + GW'(1)) >>> 1) : bx);
        size_ok = (h_s + (p_s <<< 1) >= GW'(3)) && (w_s + (p_s <<< 1) >= GW'(3));
        oh = (s2 ? ((h_s + (p_s <<< 1) - GW'(3)) >>> 1) : (h_s + (p_s <<< 1) - GW'(3)))
             + GW'(1);
        ow = (s2 ? ((w_s + (p_s <<< 1) - GW'(3)) >>> 1) : (w_s + (p_s <<< 1) - GW'(3)))
             + GW'(1);
        vy[0] = completes(oy0, s2, p_s, h_s, oh, ry);
        vy[1] = completes(oy0 + GW'(1), s2, p_s, h_s, oh, ry);
        vx[0] = completes(ox0, s2, p_s, w_s, ow, cx);
        vx[1] = completes(ox0 + GW'(1), s2, p_s, w_s, ow, cx);
    end

    // Tap address generation.
    logic signed [GW-1:0] oy, ox, iy, ix;
    logic                 tap_ok;
    logic [1:0]           dy, rd_slot;
    logic [2:0]           slot_sum;
    logic [LS_AW-1:0]     ls_rd_addr, ls_wr_addr;
    logic [WT_AW-1:0]     wt_rd_addr, wt_wr_addr;

    always_comb
    begin
        oy = oy0_reg + GW'(cand_reg[1]);
        ox = ox0_reg + GW'(cand_reg[0]);
        iy = (s2 ? (oy <<< 1) : oy) - p_s + GW'(ky_reg);
        ix = (s2 ? (ox <<< 1) : ox) - p_s + GW'(kx_reg);
        tap_ok = (iy >= 0) && (iy < h_s) && (ix >= 0) && (ix < w_s);
        dy = 2'(GW'(cur_r_reg) - iy);
        slot_sum = 3'(cur_slot_reg) + 3'd3 - 3'(dy);
        rd_slot  = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];
        ls_rd_addr = LS_AW'(STORE_ROW) * LS_AW'(rd_slot)
                   + LS_AW'(MAX_CHANNELS) * LS_AW'(ix[COL_W-1:0]) + LS_AW'(cur_ch_reg);
        ls_wr_addr = LS_AW'(STORE_ROW) * LS_AW'(slot_reg)
                   + LS_AW'(MAX_CHANNELS) * LS_AW'(col_reg) + LS_AW'(chan_reg);
        wt_rd_addr = WT_AW'(MAX_CHANNELS) * WT_AW'(tap_reg) + WT_AW'(cur_ch_reg);
        wt_wr_addr = WT_AW'(MAX_CHANNELS) * WT_AW'(tap_index) + WT_AW'(chan_index);
    end

    // Memories.
    logic [MULT_W-1:0] mult_load;
    assign mult_load = coefficient[COEF_W-1] ? '0 :
                       (coefficient[COEF_W-2:MULT_W] != '0) ? '1 : coefficient[MULT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && is_pixel)
        begin
            line_store[ls_wr_addr] <= sample_value;
        end
        if (accept && kind == KIND_WEIGHT && load_ok && tap_index <= 4'd8)
        begin
            weight_mem[wt_wr_addr] <= sample_value;
        end
        if (accept && kind == KIND_MULT && load_ok)
        begin
            mult_mem[CH_W'(chan_index)] <= mult_load;
        end
        if (accept && kind == KIND_BIAS && load_ok)
        begin
            bias_mem[CH_W'(chan_index)] <= coefficient;
        end
        ls_rd_reg   <= line_store[ls_rd_addr];
        wt_rd_reg   <= weight_mem[wt_rd_addr];
        mult_rd_reg <= mult_mem[cur_ch_reg];
        bias_rd_reg <= bias_ok_reg[cur_ch_reg] ? bias_mem[cur_ch_reg] : '0;
    end

    // Requantizer.
    rq_ctrl_t          rq_ctrl;
    logic              rq_done;
    logic signed [7:0] rq_value;

    assign rq_ctrl.start = (state_reg == ST_START);
    assign rq_ctrl.relu  = relu_reg;
    assign rq_ctrl.shift = k_eff;

    dwc3_requant u_requant (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rq_ctrl),
        .acc   (acc_reg),
        .mult  (mult_rd_reg),
        .bias  (bias_rd_reg),
        .done  (rq_done),
        .value (rq_value)
    );

    // Candidate pick: lowest pending one in output raster order.
    logic [1:0] pick;
    logic [3:0] mask_rest;
    always_comb
    begin
        priority casez (cand_mask_reg)
            4'b???1: pick = 2'd0;
            4'b??10: pick = 2'd1;
            4'b?100: pick = 2'd2;
            default: pick = 2'd3;
        endcase
        mask_rest = cand_mask_reg & ~(4'b0001 << pick);
    end

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            height_reg    <= 13'd3;
            width_reg     <= 9'd3;
            chans_reg     <= 6'd1;
            stride_reg    <= 2'd1;
            pad_reg       <= 1'b1;
            relu_reg      <= 1'b0;
            shift_reg     <= 6'd24;
            row_reg       <= '0;
            col_reg       <= '0;
            chan_reg      <= '0;
            slot_reg      <= '0;
            bias_ok_reg   <= '0;
            out_valid_reg <= 1'b0;
            tap_v_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            tap_v_reg <= (state_reg == ST_TAP);
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_HEIGHT: height_reg <= pwdata[12:0];
                    REG_WIDTH:  width_reg  <= pwdata[8:0];
                    REG_CHANS:  chans_reg  <= pwdata[5:0];
                    REG_STRIDE: stride_reg <= pwdata[1:0];
                    REG_PAD:    pad_reg    <= pwdata[0];
                    REG_RELU:   relu_reg   <= pwdata[0];
                    REG_SHIFT:  shift_reg  <= pwdata[5:0];
                    default:    ;
                endcase
                if (cfg_idx <= REG_PAD)
                begin
                    row_reg  <= '0;
                    col_reg  <= '0;
                    chan_reg <= '0;
                    slot_reg <= '0;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && kind == KIND_BIAS && load_ok)
                    begin
                        bias_ok_reg[CH_W'(chan_index)] <= 1'b1;
                    end
                    if (accept && is_pixel && !cfg_wr)
                    begin
                        cur_r_reg    <= row_reg;
                        cur_c_reg    <= col_reg;
                        cur_ch_reg   <= chan_reg;
                        cur_slot_reg <= slot_reg;
                        state_reg    <= ST_PLAN;
                        if (GW'(chan_reg) + GW'(1) >= c_s)
                        begin
                            chan_reg <= '0;
                            if (GW'(col_reg) + GW'(1) >= w_s)
                            begin
                                col_reg <= '0;
                                if (GW'(row_reg) + GW'(1) >= h_s)
                                begin
                                    row_reg  <= '0;
                                    slot_reg <= '0;
                                end
                                else
                                begin
                                    row_reg  <= row_reg + 12'd1;
                                    slot_reg <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                                end
                            end
                            else
                            begin
                                col_reg <= col_reg + COL_W'(1);
                            end
                        end
                        else
                        begin
                            chan_reg <= chan_reg + CH_W'(1);
                        end
                    end
                end
                ST_PLAN:
                begin
                    oy0_reg <= oy0;
                    ox0_reg <= ox0;
                    cand_mask_reg <= size_ok ? {vy[1] & vx[1], vy[1] & vx[0],
                                                vy[0] & vx[1], vy[0] & vx[0]} : 4'b0000;
                    state_reg <= ST_FIND;
                end
                ST_FIND:
                begin
                    if (cand_mask_reg == 4'b0000)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cand_reg      <= pick;
                        cand_mask_reg <= mask_rest;
                        last_reg      <= (mask_rest == 4'b0000);
                        acc_reg       <= '0;
                        tap_reg       <= '0;
                        ky_reg        <= '0;
                        kx_reg        <= '0;
                        state_reg     <= ST_TAP;
                    end
                end
                ST_TAP:
                begin
                    tap_ok_reg <= tap_ok;
                    tap_reg    <= tap_reg + 4'd1;
                    if (kx_reg == 2'd2)
                    begin
                        kx_reg <= '0;
                        ky_reg <= ky_reg + 2'd1;
                    end
                    else
                    begin
                        kx_reg <= kx_reg + 2'd1;
                    end
                    if (tap_reg == 4'd8)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (rq_done && out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_value_reg   <= rq_value;
                        out_row_reg     <= oy[11:0];
                        out_col_reg     <= ox[COL_W-1:0];
                        out_chan_reg    <= cur_ch_reg;
                        last_of_run_reg <= last_reg;
                        state_reg       <= ST_FIND;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // Registered read data arrive in the cycle after each tap is issued.
            if (tap_v_reg && tap_ok_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(ls_rd_reg * wt_rd_reg);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_chan    = out_chan_reg;
    assign last_of_run = last_of_run_reg;

endmodule

FILE: test/tb_top.sv
// Self-checking bench for the depthwise 3x3 int8 convolution with requantization.
// Drives requests and APB register writes, predicts every result and checks it.
// Depends on dwc3_pkg and the depthwise_conv3x3_int8_requant_unit design.
`timescale 1ns / 1ps

module tb_top;
    import dwc3_pkg::*;

    typedef struct packed {
        logic signed [7:0] value;
        logic [11:0]       row;
        logic [7:0]        col;
        logic [4:0]        chan;
        logic              last;
    } conv_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = KIND_PIXEL;
    logic signed [7:0] sample_value = '0;
    logic [4:0] chan_index = '0;
    logic [3:0] tap_index = '0;
    logic signed [47:0] coefficient = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [7:0] out_value;
    logic [11:0] out_row;
    logic [7:0] out_col;
    logic [4:0] out_chan;
    logic last_of_run;

    depthwise_conv3x3_int8_requant_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .sample_value(sample_value), .chan_index(chan_index),
        .tap_index(tap_index), .coefficient(coefficient),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_value(out_value), .out_row(out_row), .out_col(out_col),
        .out_chan(out_chan), .last_of_run(last_of_run)
    );

    always #2 clk = ~clk;

    // Mirror of the block's registers and tables.
    int unsigned rows_reg, cols_reg, chans_reg, stride_reg, pad_reg, relu_reg, shift_reg;
    int unsigned row_pos, col_pos, chan_pos;
    byte         pixel_rows [3][256][32];
    byte         kernel_taps [9][32];
    longint      scale_mult [32];
    longint      offset_bias [32];

    conv_result_t expected_results [$];
    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  requests_sent = 0;
    int  quiet_cycles = 0;

    function automatic bit window_done(int o, int s, int p, int n, int on, int x);
        int last;
        if (o < 0 || o >= on)
            return 0;
        last = o * s - p + 2;
        if (last > n - 1)
            last = n - 1;
        return last == x;
    endfunction

    function automatic int first_window(int x, int s, int p);
        int b;
        b = x + p - 2;
        return (b <= 0) ? 0 : (b + s - 1) / s;
    endfunction

    function automatic longint round_even(longint s, int k);
        longint q, r, half;
        if (k == 0)
            return s;
        q = s >>> k;
        r = s - (q <<< k);
        half = longint'(1) <<< (k - 1);
        if (r > half || (r == half && q[0]))
            q++;
        return q;
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void predict_request(logic [1:0] k_in, logic signed [7:0] val,
                                            logic [4:0] ci, logic [3:0] tap,
                                            logic signed [47:0] coef);
        int H, W, C, s, p, r, c, ch, oy0, ox0, OH, OW, oy, ox, ky, kx, iy, ix, acc, k;
        longint sum, q, cv;
        conv_result_t res;
        conv_result_t run [$];
        cv = coef;
        if (k_in == KIND_WEIGHT) begin
            if (tap <= 8)
                kernel_taps[tap][ci] = val;
            return;
        end
        if (k_in == KIND_MULT) begin
            scale_mult[ci] = cv < 0 ? 0 : (cv > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : cv);
            return;
        end
        if (k_in == KIND_BIAS) begin
            offset_bias[ci] = cv;
            return;
        end
        H = clamp_int(rows_reg, 1, 4096);
        W = clamp_int(cols_reg, 1, 256);
        C = clamp_int(chans_reg, 1, 32);
        s = clamp_int(stride_reg, 1, 2);
        p = pad_reg;
        r = row_pos;
        c = col_pos;
        ch = chan_pos;
        pixel_rows[r % 3][c][ch] = val;
        if (H + 2 * p >= 3 && W + 2 * p >= 3) begin
            oy0 = first_window(r, s, p);
            ox0 = first_window(c, s, p);
            k = shift_reg > 47 ? 47 : shift_reg;
            OH = (H + 2 * p - 3) / s + 1;
            OW = (W + 2 * p - 3) / s + 1;
            for (oy = oy0; oy <= oy0 + 1; oy++) begin
                if (!window_done(oy, s, p, H, OH, r))
                    continue;
                for (ox = ox0; ox <= ox0 + 1; ox++) begin
                    if (!window_done(ox, s, p, W, OW, c))
                        continue;
                    acc = 0;
                    for (ky = 0; ky < 3; ky++) begin
                        iy = oy * s - p + ky;
                        if (iy < 0 || iy >= H)
                            continue;
                        for (kx = 0; kx < 3; kx++) begin
                            ix = ox * s - p + kx;
                            if (ix < 0 || ix >= W)
                                continue;
                            acc += int'(pixel_rows[iy % 3][ix][ch]) *
                                   int'(kernel_taps[ky * 3 + kx][ch]);
                        end
                    end
                    sum = longint'(acc) * scale_mult[ch] + offset_bias[ch];
                    if (relu_reg != 0 && sum < 0)
                        sum = 0;
                    q = round_even(sum, k);
                    if (q > 127) q = 127;
                    if (q < -128) q = -128;
                    res.value = q[7:0];
                    res.row = oy[11:0];
                    res.col = ox[7:0];
                    res.chan = ch[4:0];
                    res.last = 1'b0;
                    run.push_back(res);
                end
            end
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                expected_results.push_back(run[i]);
        end
        ch++;
        if (ch >= C) begin
            ch = 0;
            c++;
            if (c >= W) begin
                c = 0;
                r++;
                if (r >= H)
                    r = 0;
            end
        end
        row_pos = r;
        col_pos = c;
        chan_pos = ch;
    endfunction

    // One request on the input channel; the prediction is made at acceptance.
    task automatic send_request(logic [1:0] k_in, logic signed [7:0] val, logic [4:0] ci,
                                logic [3:0] tap, logic signed [47:0] coef);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k_in;
        sample_value <= val;
        chan_index <= ci;
        tap_index <= tap;
        coefficient <= coef;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(k_in, val, ci, tap, coef);
        requests_sent++;
    endtask

    task automatic send_pixel(logic signed [7:0] val);
        send_request(KIND_PIXEL, val, 5'($urandom), 4'($urandom), 48'({$urandom, $urandom}));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, int unsigned value);
        logic [31:0] data;
        data = value;
        // Upper bits beyond the field width are junk and must be ignored.
        case (idx)
            REG_HEIGHT: data[31:13] = 19'($urandom);
            REG_WIDTH:  data[31:9]  = 23'($urandom);
            REG_CHANS:  data[31:6]  = 26'($urandom);
            REG_STRIDE: data[31:2]  = 30'($urandom);
            REG_PAD:    data[31:1]  = 31'($urandom);
            REG_RELU:   data[31:1]  = 31'($urandom);
            default:    data[31:6]  = 26'($urandom);
        endcase
        // Registers change only once the block has gone quiet.
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0 || in_stall)
            @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEIGHT: rows_reg = data[12:0];
            REG_WIDTH:  cols_reg = data[8:0];
            REG_CHANS:  chans_reg = data[5:0];
            REG_STRIDE: stride_reg = data[1:0];
            REG_PAD:    pad_reg = data[0];
            REG_RELU:   relu_reg = data[0];
            default:    shift_reg = data[5:0];
        endcase
        if (idx <= REG_PAD)
        begin
            row_pos = 0;
            col_pos = 0;
            chan_pos = 0;
        end
    endtask

    task automatic set_geometry(int unsigned h, int unsigned w, int unsigned c, int unsigned s,
                                int unsigned p, int unsigned relu, int unsigned shift);
        write_register(REG_HEIGHT, h);
        write_register(REG_WIDTH, w);
        write_register(REG_CHANS, c);
        write_register(REG_STRIDE, s);
        write_register(REG_PAD, p);
        write_register(REG_RELU, relu);
        write_register(REG_SHIFT, shift);
    endtask

    function automatic longint pick_multiplier();
        return longint'($urandom) >> $urandom_range(0, 31);
    endfunction

    // Channels used by the frames below.
    task automatic load_all_tables();
        for (int ch = 0; ch < 4; ch++)
        begin
            for (int t = 0; t < 9; t++)
                send_request(KIND_WEIGHT, 8'($urandom), 5'(ch), 4'(t), '0);
            send_request(KIND_MULT, 8'($urandom), 5'(ch), 4'($urandom),
                         48'(pick_multiplier()));
        end
    endtask

    int unsigned frame_pixels;

    // Extremes of pixels and weights, load clamps and ignored taps on the reset geometry.
    task automatic test_extremes();
        send_request(KIND_WEIGHT, 8'sd127, 5'd0, 4'd9, '0);
        send_request(KIND_WEIGHT, 8'sd5, 5'd0, 4'd15, '0);
        for (int t = 0; t < 9; t++)
            send_request(KIND_WEIGHT, (t % 2) ? 8'sh80 : 8'sd127, 5'd0, 4'(t), '0);
        send_request(KIND_MULT, '0, 5'd0, '0, -48'sd5);
        send_request(KIND_MULT, '0, 5'd0, '0, 48'h7FFF_FFFF_FFFF);
        send_request(KIND_BIAS, '0, 5'd0, '0, 48'sh8000_0000_0000);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'sh80 : 8'sd127);
        drain_results();
        send_request(KIND_MULT, '0, 5'd0, '0, 48'd1 << 16);
        send_request(KIND_BIAS, '0, 5'd0, '0, 48'sh7FFF_FFFF_FFFF);
        for (int i = 0; i < 9; i++)
            send_pixel(8'sh80);
        drain_results();
        send_request(KIND_BIAS, '0, 5'd0, '0, '0);
    endtask

    // Rounding and clamping: shifts 0, 11, 22, 33, 44 and 55 with a negative bias, with and without relu.
    task automatic test_rounding();
        set_geometry(3, 3, 1, 1, 0, 0, 0);
        send_request(KIND_MULT, '0, 5'd0, '0, 48'd1);
        for (int t = 0; t < 9; t++)
            send_request(KIND_WEIGHT, (t == 0) ? 8'sd1 : 8'sd0, 5'd0, 4'(t), '0);
        for (int sh = 0; sh < 64; sh += 11)
        begin
            write_register(REG_SHIFT, sh);
            write_register(REG_RELU, sh % 2);
            send_request(KIND_BIAS, '0, 5'd0, '0, -48'sd1 <<< (sh > 0 ? sh - 1 : 0));
            for (int i = 0; i < 9; i++)
                send_pixel(8'($urandom));
            drain_results();
        end
    endtask

    // Undersized frames, out-of-range registers and the tallest frame.
    task automatic test_geometry_limits();
        load_all_tables();
        set_geometry(1, 1, 1, 1, 0, 0, 20);
        repeat (4) send_pixel(8'($urandom));
        set_geometry(2, 5, 2, 1, 0, 0, 20);
        repeat (10) send_pixel(8'($urandom));
        drain_results();
        set_geometry(0, 0, 0, 0, 1, 1, 63);
        repeat (6) send_pixel(8'($urandom));
        drain_results();
        set_geometry(8191, 511, 63, 3, 1, 0, 24);
        repeat (10) send_pixel(8'($urandom));
        drain_results();
        set_geometry(4096, 1, 1, 1, 1, 1, 22);
        repeat (12) send_pixel(8'($urandom));
        drain_results();
    endtask

    // Random frames with random content; a few loads and cut-short frames as noise.
    task automatic test_random_frames(int quota);
        int start_count;
        int unsigned h, w, c, s, p;
        start_count = requests_sent;
        while (requests_sent - start_count < quota)
        begin
            h = $urandom_range(1, 5);
            w = $urandom_range(1, 6);
            c = $urandom_range(1, 3);
            s = $urandom_range(0, 3);
            p = $urandom_range(0, 1);
            set_geometry(h, w, c, s, p, $urandom_range(0, 1),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(12, 30));
            frame_pixels = h * w * c;
            if ($urandom_range(0, 5) == 0)
                frame_pixels = $urandom_range(1, frame_pixels);
            for (int i = 0; i < frame_pixels; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: send_request(KIND_WEIGHT, 8'($urandom), 5'($urandom),
                                        4'($urandom), 48'({$urandom, $urandom}));
                        1: send_request(KIND_MULT, 8'($urandom), 5'($urandom), 4'($urandom),
                                        ($urandom_range(0, 7) == 0)
                                            ? 48'({$urandom, $urandom})
                                            : 48'(pick_multiplier()));
                        default: send_request(KIND_BIAS, 8'($urandom), 5'($urandom),
                                              4'($urandom),
                                              48'sh7FFF_FFFF_FFFF >>> $urandom_range(0, 47)
                                                  ^ -48'($urandom_range(0, 1)));
                    endcase
                end
                send_pixel(8'($urandom));
            end
            drain_results();
        end
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic test_hold_off();
        set_geometry(4, 4, 2, 1, 1, 0, 20);
        for (int i = 0; i < 24; i++)
        begin
            send_pixel(8'($urandom));
            if (i % 8 == 7)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait (expected_results.size() == 0);
            end
        end
        drain_results();
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result value=%0d row=%0d col=%0d chan=%0d last=%0b",
                         $time, out_value, out_row, out_col, out_chan, last_of_run);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_value !== want.value || out_row !== want.row || out_col !== want.col ||
                    out_chan !== want.chan || last_of_run !== want.last)
                begin
                    error_count++;
                    $display("%0t: mismatch expected v=%0d r=%0d c=%0d ch=%0d l=%0b, got v=%0d r=%0d c=%0d ch=%0d l=%0b",
                             $time, want.value, want.row, want.col, want.chan, want.last,
                             out_value, out_row, out_col, out_chan, last_of_run);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rows_reg = 3; cols_reg = 3; chans_reg = 1; stride_reg = 1;
        pad_reg = 1; relu_reg = 0; shift_reg = 24;
        row_pos = 0; col_pos = 0; chan_pos = 0;
        foreach (offset_bias[i])
            offset_bias[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 49;
        test_extremes();
        test_rounding();
        test_geometry_limits();
        test_random_frames(15);
        test_hold_off();
        send_idle_pct = 49;
        recv_idle_pct = 33;
        test_random_frames(15);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(15);
        drain_results();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
design/dwc3_pkg.sv
design/dwc3_requant.sv
design/depthwise_conv3x3_int8_requant_unit.sv
test/tb_top.sv
